// File: src/assert_macros.svh
// Assertion shorthands, clocked on aclk and disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define CHK_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

`define CHK_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`define CHK_IMPLY_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/mbed_pkg.sv
package mbed_pkg;

    localparam int NUM_BUTTONS = 5;
    localparam int NUM_AXES    = 3;
    localparam int AXIS_WIDTH  = 16;

    localparam int BTN_FIELD_W  = 5;
    localparam int ELAPSED_W    = 16;
    localparam int AXIS_FIELDS  = 3;
    localparam int AXIS_FIELD_W = 16;
    localparam int MASK_W       = 5;
    localparam int INTERVAL_W   = 16;
    localparam int TIMER_W      = 32;
    localparam int CFG_ADDR_W   = 4;
    localparam int CFG_DATA_W   = 16;

    localparam int KIND_W    = 3;
    localparam int BTN_IDX_W = 3;
    localparam int AXI_IDX_W = 2;

    localparam int IN_RAW_W = BTN_FIELD_W + ELAPSED_W + AXIS_FIELDS * AXIS_FIELD_W;
    localparam int IN_W     = ((IN_RAW_W + 7) / 8) * 8;
    localparam int OUT_RAW_W = BTN_IDX_W + AXI_IDX_W + AXIS_WIDTH;
    localparam int OUT_W     = ((OUT_RAW_W + 7) / 8) * 8;

    localparam int REM_W        = $clog2(NUM_BUTTONS + 1);
    localparam int EV_PER_BTN   = 4;
    localparam int BTN_SLOTS    = NUM_BUTTONS * EV_PER_BTN;
    localparam int SLOTS        = BTN_SLOTS + NUM_AXES;
    localparam int SLOT_W       = $clog2(SLOTS);
    localparam int AXIS_SEL_W   = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

    localparam logic [CFG_ADDR_W-1:0] REG_LISTEN_MASK = 4'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_INTERVAL    = 4'd1;
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET  = 16'd700;

    localparam int LM_DOWN   = 0;
    localparam int LM_CLICK  = 1;
    localparam int LM_DOUBLE = 2;
    localparam int LM_UP     = 3;
    localparam int LM_MOVE   = 4;

    localparam logic [1:0] SLOT_DOWN   = 2'd0;
    localparam logic [1:0] SLOT_CLICK  = 2'd1;
    localparam logic [1:0] SLOT_DOUBLE = 2'd2;
    localparam logic [1:0] SLOT_UP     = 2'd3;

    typedef enum logic [KIND_W-1:0] {
        EV_DOWN   = 3'd0,
        EV_CLICK  = 3'd1,
        EV_DOUBLE = 3'd2,
        EV_UP     = 3'd3,
        EV_MOVE   = 3'd4,
        EV_NONE   = 3'd5
    } mbed_kind_t;

    // per-button findings; low four bits are the event slots in emit order
    typedef struct packed {
        logic press;
        logic up;
        logic dbl;
        logic click;
        logic down;
    } mbed_lane_t;

    typedef struct packed {
        logic busy;
        logic ready;
    } mbed_merge_stat_t;

endpackage

// File: src/mouse_button_event_detector.sv
// Mouse button event detector. Each s_ beat is one poll: pressed buttons,
// ticks elapsed and three axis samples. Buttons are checked side by side in
// one lane each (down, click, double click, up) and axes in one lane each
// (move); the poll's events then leave on m_ one beat per cycle while m_tready
// does not stall them, the event kind on m_tuser, buttons 0 to 4 and then axes
// x, y, z, with m_tlast on the final beat. A poll with no event gives a single
// "no event" beat. A poll gives as many beats as it has events, 1 to 14 (only
// the first press of a poll can be a double click), all from the single output
// serializer; the next poll is taken in the cycle its predecessor's final beat
// is produced, so polls stream without gaps. Registers: index 0 listen mask,
// index 1 double-click window in ticks (reset 700).
`include "assert_macros.svh"

module mouse_button_event_detector import mbed_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // buttons_pressed, elapsed_ticks, axis_x, axis_y, axis_z, zero pad
    input  logic [IN_W-1:0]       s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // button_index, axis_index, axis_value, zero pad
    output logic [OUT_W-1:0]      m_tdata,
    // event_kind
    output logic [KIND_W-1:0]     m_tuser,
    output logic                  m_tlast
);

    logic [MASK_W-1:0]     mask_reg;
    logic [INTERVAL_W-1:0] interval_reg;

    logic [NUM_BUTTONS-1:0]              prev_btn_reg;
    logic [NUM_AXES-1:0][AXIS_WIDTH-1:0] prev_axes_reg;
    logic [REM_W-1:0]                    rem_reg, rem_next;
    logic [TIMER_W-1:0]                  timer_reg, timer_next;

    logic                         s_acc;
    logic [BTN_FIELD_W-1:0]       btn_field;
    logic [ELAPSED_W-1:0]         elapsed;
    logic [NUM_BUTTONS-1:0]       now_btn;
    logic signed [NUM_AXES-1:0][AXIS_WIDTH-1:0] now_axes;

    logic [TIMER_W:0]       timer_sum;
    logic [TIMER_W-1:0]     timer_sat;
    logic [TIMER_W-1:0]     timer_mid;
    logic                   timer_ok;

    mbed_lane_t             lane [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0] press_vec;
    logic [NUM_BUTTONS-1:0] dbl_vec;
    logic [NUM_BUTTONS:0]   lower_any;
    logic [NUM_BUTTONS:1]   higher_any;
    logic [NUM_BUTTONS-1:0] is_last;
    logic [REM_W-1:0]       last_code;
    logic                   any_press;
    logic [NUM_AXES-1:0]    moved;
    logic [SLOTS-1:0]       ev_bits;

    mbed_merge_stat_t       mstat;

    assign s_acc     = s_tvalid && s_tready;
    assign s_tready  = mstat.ready;
    assign btn_field = s_tdata[BTN_FIELD_W-1:0];
    assign elapsed   = s_tdata[BTN_FIELD_W +: ELAPSED_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg     <= '0;
            interval_reg <= INTERVAL_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_LISTEN_MASK: mask_reg     <= cfg_wdata[MASK_W-1:0];
                REG_INTERVAL:    interval_reg <= cfg_wdata[INTERVAL_W-1:0];
                default: ;
            endcase
        end
    end

    assign timer_sum = {1'b0, timer_reg} + (TIMER_W + 1)'(elapsed);
    assign timer_sat = timer_sum[TIMER_W] ? '1 : timer_sum[TIMER_W-1:0];
    assign timer_ok  = timer_sat < TIMER_W'(interval_reg);

    for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_btn
        if (b < BTN_FIELD_W) begin : g_in
            assign now_btn[b] = btn_field[b];
        end else begin : g_zero
            assign now_btn[b] = 1'b0;
        end

        mbed_button_lane u_lane (
            .was_pressed (prev_btn_reg[b]),
            .is_pressed  (now_btn[b]),
            .listen_mask (mask_reg),
            .rem_hit     (rem_reg == REM_W'(b + 1)),
            .timer_ok    (timer_ok),
            .lower_press (lower_any[b]),
            .lane        (lane[b])
        );

        assign press_vec[b] = lane[b].press;
        assign dbl_vec[b]   = lane[b].dbl;
        assign ev_bits[b*EV_PER_BTN +: EV_PER_BTN] =
            {lane[b].up, lane[b].dbl, lane[b].click, lane[b].down};
    end

    always_comb begin
        lower_any[0] = 1'b0;
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            lower_any[b+1] = lower_any[b] | press_vec[b];
        end
        higher_any[NUM_BUTTONS] = 1'b0;
        for (int b = NUM_BUTTONS - 1; b >= 1; b--) begin
            higher_any[b] = higher_any[b+1] | press_vec[b];
        end
    end

    always_comb begin
        last_code = '0;
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            is_last[b] = press_vec[b] && !higher_any[b+1];
            if (is_last[b]) begin
                last_code = last_code | REM_W'(b + 1);
            end
        end
    end

    assign any_press = lower_any[NUM_BUTTONS];

    // window expiry applies after the presses of this poll
    always_comb begin
        rem_next  = rem_reg;
        timer_mid = timer_sat;
        if (any_press) begin
            rem_next  = ((is_last & dbl_vec) != '0) ? '0 : last_code;
            timer_mid = '0;
        end
        timer_next = timer_mid;
        if (timer_mid >= TIMER_W'(interval_reg)) begin
            rem_next   = '0;
            timer_next = '0;
        end
    end

    for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
        if (a < AXIS_FIELDS) begin : g_in
            assign now_axes[a] = AXIS_WIDTH'($signed(
                s_tdata[BTN_FIELD_W + ELAPSED_W + a*AXIS_FIELD_W +: AXIS_FIELD_W]));
        end else begin : g_zero
            assign now_axes[a] = '0;
        end

        mbed_axis_lane u_lane (
            .move_en   (mask_reg[LM_MOVE]),
            .axis_now  (now_axes[a]),
            .axis_prev (prev_axes_reg[a]),
            .moved     (moved[a])
        );

        assign ev_bits[BTN_SLOTS + a] = moved[a];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_btn_reg  <= '0;
            prev_axes_reg <= '0;
            rem_reg       <= '0;
            timer_reg     <= '0;
        end else if (s_acc) begin
            prev_btn_reg  <= now_btn;
            prev_axes_reg <= now_axes;
            rem_reg       <= rem_next;
            timer_reg     <= timer_next;
        end
    end

    mbed_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (s_acc),
        .load_bits (ev_bits),
        .load_axes (now_axes),
        .stat      (mstat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    `CHK_IMPLY_NEXT(a_load_busy, s_acc, mstat.busy, "accepted poll not held by serializer")
    `CHK_ALWAYS(a_rem_range, rem_reg <= REM_W'(NUM_BUTTONS), "remembered button out of range")
    `CHK_IMPLY(a_none_last, m_tvalid && (m_tuser == EV_NONE), m_tlast,
        "no-event beat without tlast")

endmodule

// File: src/mbed_button_lane.sv
module mbed_button_lane import mbed_pkg::*; (
    input  logic              was_pressed,
    input  logic              is_pressed,
    input  logic [MASK_W-1:0] listen_mask,
    input  logic              rem_hit,
    input  logic              timer_ok,
    input  logic              lower_press,
    output mbed_lane_t        lane
);

    logic press;
    logic release_edge;

    assign press        = is_pressed && !was_pressed;
    assign release_edge = was_pressed && !is_pressed;

    // only the lowest pressed button of a poll sees the running timer
    always_comb begin
        lane.press = press;
        lane.down  = press && listen_mask[LM_DOWN];
        lane.click = press && listen_mask[LM_CLICK];
        lane.dbl   = press && listen_mask[LM_DOUBLE] && rem_hit && timer_ok && !lower_press;
        lane.up    = release_edge && listen_mask[LM_UP];
    end

endmodule

// File: src/mbed_axis_lane.sv
module mbed_axis_lane import mbed_pkg::*; (
    input  logic                         move_en,
    input  logic signed [AXIS_WIDTH-1:0] axis_now,
    input  logic signed [AXIS_WIDTH-1:0] axis_prev,
    output logic                         moved
);

    assign moved = move_en && (axis_now != axis_prev);

endmodule

// File: src/mbed_merge.sv
module mbed_merge import mbed_pkg::*; (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     load,
    input  logic [SLOTS-1:0]                         load_bits,
    input  logic signed [NUM_AXES-1:0][AXIS_WIDTH-1:0] load_axes,
    output mbed_merge_stat_t                         stat,
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    output logic [OUT_W-1:0]                         m_tdata,
    output logic [KIND_W-1:0]                        m_tuser,
    output logic                                     m_tlast
);

    logic                              slot_valid_reg;
    logic [SLOTS-1:0]                  bits_reg;
    logic [NUM_AXES-1:0][AXIS_WIDTH-1:0] axes_reg;

    logic                    m_valid_reg;
    mbed_kind_t              kind_reg, kind_next;
    logic [BTN_IDX_W-1:0]    btn_reg, btn_next;
    logic [AXI_IDX_W-1:0]    axi_reg, axi_next;
    logic [AXIS_WIDTH-1:0]   val_reg, val_next;
    logic                    last_reg;

    logic                  out_free;
    logic                  emit;
    logic [SLOTS-1:0]      onehot;
    logic [SLOTS-1:0]      rest;
    logic [SLOT_W-1:0]     idx;
    logic [AXIS_SEL_W-1:0] asel;

    assign out_free = !m_valid_reg || m_tready;
    assign emit     = slot_valid_reg && out_free;
    assign onehot   = bits_reg & (~bits_reg + SLOTS'(1));
    assign rest     = bits_reg & ~onehot;

    always_comb begin
        idx = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (onehot[i]) begin
                idx = idx | SLOT_W'(i);
            end
        end
    end

    assign asel = AXIS_SEL_W'(idx - SLOT_W'(BTN_SLOTS));

    always_comb begin
        kind_next = EV_NONE;
        btn_next  = '0;
        axi_next  = '0;
        val_next  = '0;
        if (bits_reg != '0) begin
            if (idx < SLOT_W'(BTN_SLOTS)) begin
                btn_next = BTN_IDX_W'(idx >> 2);
                case (idx[1:0])
                    SLOT_DOWN:   kind_next = EV_DOWN;
                    SLOT_CLICK:  kind_next = EV_CLICK;
                    SLOT_DOUBLE: kind_next = EV_DOUBLE;
                    SLOT_UP:     kind_next = EV_UP;
                    default:     kind_next = EV_NONE;
                endcase
            end else begin
                kind_next = EV_MOVE;
                axi_next  = AXI_IDX_W'(asel);
                val_next  = axes_reg[asel];
            end
        end
    end

    assign stat.busy  = slot_valid_reg;
    assign stat.ready = !slot_valid_reg || (emit && rest == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_valid_reg <= 1'b0;
        end else if (load) begin
            slot_valid_reg <= 1'b1;
        end else if (emit && rest == '0) begin
            slot_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            bits_reg <= load_bits;
            axes_reg <= load_axes;
        end else if (emit) begin
            bits_reg <= rest;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            kind_reg <= kind_next;
            btn_reg  <= btn_next;
            axi_reg  <= axi_next;
            val_reg  <= val_next;
            last_reg <= (rest == '0);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_W'({val_reg, axi_reg, btn_reg});
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;

endmodule
